### design/hpe_pkg.sv
// ----------------------------------------------------------------------------
// hpe_pkg
// Types, static Huffman code table and shared constants for the HPACK string
// encoder.
// ----------------------------------------------------------------------------
package hpe_pkg;

   localparam int CODE_W = 30;
   localparam int LEN_W  = 5;

   typedef struct packed {
      logic [7:0]  symbol;
      logic        first;
      logic        final_req;
      logic [15:0] room;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       out_end;
      logic       overflow;
   } rsp_type;

   // One classified item handed from the front part to the back part.
   typedef struct packed {
      logic [CODE_W-1:0] code;
      logic [LEN_W-1:0]  len;
      logic              first;
      logic              final_req;
      logic [15:0]       room;
   } job_type;

   function automatic logic [CODE_W-1:0] huff_code(input logic [7:0] s);
      logic [CODE_W-1:0] c;
      case (s)
         8'd0: c = 30'h1ff8; 8'd1: c = 30'h7fffd8; 8'd2: c = 30'hfffffe2;
         8'd3: c = 30'hfffffe3; 8'd4: c = 30'hfffffe4; 8'd5: c = 30'hfffffe5;
         8'd6: c = 30'hfffffe6; 8'd7: c = 30'hfffffe7; 8'd8: c = 30'hfffffe8;
         8'd9: c = 30'hffffea; 8'd10: c = 30'h3ffffffc; 8'd11: c = 30'hfffffe9;
         8'd12: c = 30'hfffffea; 8'd13: c = 30'h3ffffffd; 8'd14: c = 30'hfffffeb;
         8'd15: c = 30'hfffffec; 8'd16: c = 30'hfffffed; 8'd17: c = 30'hfffffee;
         8'd18: c = 30'hfffffef; 8'd19: c = 30'hffffff0; 8'd20: c = 30'hffffff1;
         8'd21: c = 30'hffffff2; 8'd22: c = 30'h3ffffffe; 8'd23: c = 30'hffffff3;
         8'd24: c = 30'hffffff4; 8'd25: c = 30'hffffff5; 8'd26: c = 30'hffffff6;
         8'd27: c = 30'hffffff7; 8'd28: c = 30'hffffff8; 8'd29: c = 30'hffffff9;
         8'd30: c = 30'hffffffa; 8'd31: c = 30'hffffffb;
         8'd32: c = 30'h14; 8'd33: c = 30'h3f8; 8'd34: c = 30'h3f9; 8'd35: c = 30'hffa;
         8'd36: c = 30'h1ff9; 8'd37: c = 30'h15; 8'd38: c = 30'hf8; 8'd39: c = 30'h7fa;
         8'd40: c = 30'h3fa; 8'd41: c = 30'h3fb; 8'd42: c = 30'hf9; 8'd43: c = 30'h7fb;
         8'd44: c = 30'hfa; 8'd45: c = 30'h16; 8'd46: c = 30'h17; 8'd47: c = 30'h18;
         8'd48: c = 30'h0; 8'd49: c = 30'h1; 8'd50: c = 30'h2; 8'd51: c = 30'h19;
         8'd52: c = 30'h1a; 8'd53: c = 30'h1b; 8'd54: c = 30'h1c; 8'd55: c = 30'h1d;
         8'd56: c = 30'h1e; 8'd57: c = 30'h1f; 8'd58: c = 30'h5c; 8'd59: c = 30'hfb;
         8'd60: c = 30'h7ffc; 8'd61: c = 30'h20; 8'd62: c = 30'hffb; 8'd63: c = 30'h3fc;
         8'd64: c = 30'h1ffa; 8'd65: c = 30'h21; 8'd66: c = 30'h5d; 8'd67: c = 30'h5e;
         8'd68: c = 30'h5f; 8'd69: c = 30'h60; 8'd70: c = 30'h61; 8'd71: c = 30'h62;
         8'd72: c = 30'h63; 8'd73: c = 30'h64; 8'd74: c = 30'h65; 8'd75: c = 30'h66;
         8'd76: c = 30'h67; 8'd77: c = 30'h68; 8'd78: c = 30'h69; 8'd79: c = 30'h6a;
         8'd80: c = 30'h6b; 8'd81: c = 30'h6c; 8'd82: c = 30'h6d; 8'd83: c = 30'h6e;
         8'd84: c = 30'h6f; 8'd85: c = 30'h70; 8'd86: c = 30'h71; 8'd87: c = 30'h72;
         8'd88: c = 30'hfc; 8'd89: c = 30'h73; 8'd90: c = 30'hfd; 8'd91: c = 30'h1ffb;
         8'd92: c = 30'h7fff0; 8'd93: c = 30'h1ffc; 8'd94: c = 30'h3ffc; 8'd95: c = 30'h22;
         8'd96: c = 30'h7ffd; 8'd97: c = 30'h3; 8'd98: c = 30'h23; 8'd99: c = 30'h4;
         8'd100: c = 30'h24; 8'd101: c = 30'h5; 8'd102: c = 30'h25; 8'd103: c = 30'h26;
         8'd104: c = 30'h27; 8'd105: c = 30'h6; 8'd106: c = 30'h74; 8'd107: c = 30'h75;
         8'd108: c = 30'h28; 8'd109: c = 30'h29; 8'd110: c = 30'h2a; 8'd111: c = 30'h7;
         8'd112: c = 30'h2b; 8'd113: c = 30'h76; 8'd114: c = 30'h2c; 8'd115: c = 30'h8;
         8'd116: c = 30'h9; 8'd117: c = 30'h2d; 8'd118: c = 30'h77; 8'd119: c = 30'h78;
         8'd120: c = 30'h79; 8'd121: c = 30'h7a; 8'd122: c = 30'h7b; 8'd123: c = 30'h7ffe;
         8'd124: c = 30'h7fc; 8'd125: c = 30'h3ffd; 8'd126: c = 30'h1ffd;
         8'd127: c = 30'hffffffc;
         8'd128: c = 30'hfffe6; 8'd129: c = 30'h3fffd2; 8'd130: c = 30'hfffe7;
         8'd131: c = 30'hfffe8; 8'd132: c = 30'h3fffd3; 8'd133: c = 30'h3fffd4;
         8'd134: c = 30'h3fffd5; 8'd135: c = 30'h7fffd9; 8'd136: c = 30'h3fffd6;
         8'd137: c = 30'h7fffda; 8'd138: c = 30'h7fffdb; 8'd139: c = 30'h7fffdc;
         8'd140: c = 30'h7fffdd; 8'd141: c = 30'h7fffde; 8'd142: c = 30'hffffeb;
         8'd143: c = 30'h7fffdf; 8'd144: c = 30'hffffec; 8'd145: c = 30'hffffed;
         8'd146: c = 30'h3fffd7; 8'd147: c = 30'h7fffe0; 8'd148: c = 30'hffffee;
         8'd149: c = 30'h7fffe1; 8'd150: c = 30'h7fffe2; 8'd151: c = 30'h7fffe3;
         8'd152: c = 30'h7fffe4; 8'd153: c = 30'h1fffdc; 8'd154: c = 30'h3fffd8;
         8'd155: c = 30'h7fffe5; 8'd156: c = 30'h3fffd9; 8'd157: c = 30'h7fffe6;
         8'd158: c = 30'h7fffe7; 8'd159: c = 30'hffffef; 8'd160: c = 30'h3fffda;
         8'd161: c = 30'h1fffdd; 8'd162: c = 30'hfffe9; 8'd163: c = 30'h3fffdb;
         8'd164: c = 30'h3fffdc; 8'd165: c = 30'h7fffe8; 8'd166: c = 30'h7fffe9;
         8'd167: c = 30'h1fffde; 8'd168: c = 30'h7fffea; 8'd169: c = 30'h3fffdd;
         8'd170: c = 30'h3fffde; 8'd171: c = 30'hfffff0; 8'd172: c = 30'h1fffdf;
         8'd173: c = 30'h3fffdf; 8'd174: c = 30'h7fffeb; 8'd175: c = 30'h7fffec;
         8'd176: c = 30'h1fffe0; 8'd177: c = 30'h1fffe1; 8'd178: c = 30'h3fffe0;
         8'd179: c = 30'h1fffe2; 8'd180: c = 30'h7fffed; 8'd181: c = 30'h3fffe1;
         8'd182: c = 30'h7fffee; 8'd183: c = 30'h7fffef; 8'd184: c = 30'hfffea;
         8'd185: c = 30'h3fffe2; 8'd186: c = 30'h3fffe3; 8'd187: c = 30'h3fffe4;
         8'd188: c = 30'h7ffff0; 8'd189: c = 30'h3fffe5; 8'd190: c = 30'h3fffe6;
         8'd191: c = 30'h7ffff1; 8'd192: c = 30'h3ffffe0; 8'd193: c = 30'h3ffffe1;
         8'd194: c = 30'hfffeb; 8'd195: c = 30'h7fff1; 8'd196: c = 30'h3fffe7;
         8'd197: c = 30'h7ffff2; 8'd198: c = 30'h3fffe8; 8'd199: c = 30'h1ffffec;
         8'd200: c = 30'h3ffffe2; 8'd201: c = 30'h3ffffe3; 8'd202: c = 30'h3ffffe4;
         8'd203: c = 30'h7ffffde; 8'd204: c = 30'h7ffffdf; 8'd205: c = 30'h3ffffe5;
         8'd206: c = 30'hfffff1; 8'd207: c = 30'h1ffffed; 8'd208: c = 30'h7fff2;
         8'd209: c = 30'h1fffe3; 8'd210: c = 30'h3ffffe6; 8'd211: c = 30'h7ffffe0;
         8'd212: c = 30'h7ffffe1; 8'd213: c = 30'h3ffffe7; 8'd214: c = 30'h7ffffe2;
         8'd215: c = 30'hfffff2; 8'd216: c = 30'h1fffe4; 8'd217: c = 30'h1fffe5;
         8'd218: c = 30'h3ffffe8; 8'd219: c = 30'h3ffffe9; 8'd220: c = 30'hffffffd;
         8'd221: c = 30'h7ffffe3; 8'd222: c = 30'h7ffffe4; 8'd223: c = 30'h7ffffe5;
         8'd224: c = 30'hfffec; 8'd225: c = 30'hfffff3; 8'd226: c = 30'hfffed;
         8'd227: c = 30'h1fffe6; 8'd228: c = 30'h3fffe9; 8'd229: c = 30'h1fffe7;
         8'd230: c = 30'h1fffe8; 8'd231: c = 30'h7ffff3; 8'd232: c = 30'h3fffea;
         8'd233: c = 30'h3fffeb; 8'd234: c = 30'h1ffffee; 8'd235: c = 30'h1ffffef;
         8'd236: c = 30'hfffff4; 8'd237: c = 30'hfffff5; 8'd238: c = 30'h3ffffea;
         8'd239: c = 30'h7ffff4; 8'd240: c = 30'h3ffffeb; 8'd241: c = 30'h7ffffe6;
         8'd242: c = 30'h3ffffec; 8'd243: c = 30'h3ffffed; 8'd244: c = 30'h7ffffe7;
         8'd245: c = 30'h7ffffe8; 8'd246: c = 30'h7ffffe9; 8'd247: c = 30'h7ffffea;
         8'd248: c = 30'h7ffffeb; 8'd249: c = 30'hffffffe; 8'd250: c = 30'h7ffffec;
         8'd251: c = 30'h7ffffed; 8'd252: c = 30'h7ffffee; 8'd253: c = 30'h7ffffef;
         8'd254: c = 30'h7fffff0; 8'd255: c = 30'h3ffffee;
         default: c = '0;
      endcase
      return c;
   endfunction

   localparam logic [LEN_W-1:0] HUFF_LEN [256] = '{
      13, 23, 28, 28, 28, 28, 28, 28, 28, 24, 30, 28, 28, 30, 28, 28,
      28, 28, 28, 28, 28, 28, 30, 28, 28, 28, 28, 28, 28, 28, 28, 28,
      6, 10, 10, 12, 13, 6, 8, 11, 10, 10, 8, 11, 8, 6, 6, 6,
      5, 5, 5, 6, 6, 6, 6, 6, 6, 6, 7, 8, 15, 6, 12, 10,
      13, 6, 7, 7, 7, 7, 7, 7, 7, 7, 7, 7, 7, 7, 7, 7,
      7, 7, 7, 7, 7, 7, 7, 7, 8, 7, 8, 13, 19, 13, 14, 6,
      15, 5, 6, 5, 6, 5, 6, 6, 6, 5, 7, 7, 6, 6, 6, 5,
      6, 7, 6, 5, 5, 6, 7, 7, 7, 7, 7, 15, 11, 14, 13, 28,
      20, 22, 20, 20, 22, 22, 22, 23, 22, 23, 23, 23, 23, 23, 24, 23,
      24, 24, 22, 23, 24, 23, 23, 23, 23, 21, 22, 23, 22, 23, 23, 24,
      22, 21, 20, 22, 22, 23, 23, 21, 23, 22, 22, 24, 21, 22, 23, 23,
      21, 21, 22, 21, 23, 22, 23, 23, 20, 22, 22, 22, 23, 22, 22, 23,
      26, 26, 20, 19, 22, 23, 22, 25, 26, 26, 26, 27, 27, 26, 24, 25,
      19, 21, 26, 27, 27, 26, 27, 24, 21, 21, 26, 26, 28, 27, 27, 27,
      20, 24, 20, 21, 22, 21, 21, 23, 22, 22, 25, 25, 24, 24, 26, 23,
      26, 27, 26, 26, 27, 27, 27, 27, 27, 28, 27, 27, 27, 27, 27, 26
   };

endpackage

### design/hpack_huffman_string_encoder.sv
// ----------------------------------------------------------------------------
// hpack_huffman_string_encoder
// Static-table HPACK Huffman string encoder, one string byte per input beat.
// ----------------------------------------------------------------------------
// A front part looks up each byte's code and queues it (two entries); a back
// part emits one output byte per cycle from the bit accumulator while the
// output side accepts. Each input beat gives 0 to 4 output bytes, plus the
// padded tail on a final beat; the back part takes the next beat from the
// queue only after it has emitted every byte of the current one, and a stall
// on the output side holds it. An overflow gives one beat with overflow and
// out_end.
module hpack_huffman_string_encoder #(
   parameter int ROOM_LIMIT = 65535
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  hpe_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output hpe_pkg::rsp_type  rsp_data
);

   logic             job_valid, job_ready;
   hpe_pkg::job_type job_data;

   hpe_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .job_valid (job_valid),
      .job_ready (job_ready),
      .job_data  (job_data)
   );

   hpe_back #(.ROOM_LIMIT(ROOM_LIMIT)) u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (job_valid),
      .job_ready (job_ready),
      .job_data  (job_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

### design/hpe_front.sv
// ----------------------------------------------------------------------------
// hpe_front
// Accepts string bytes, looks up their static Huffman code and length, and
// pushes the classified beat into a two-entry queue for the back part.
// ----------------------------------------------------------------------------
module hpe_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  hpe_pkg::req_type  req_data,
   output logic              job_valid,
   input  logic              job_ready,
   output hpe_pkg::job_type  job_data
);

   hpe_pkg::job_type slot_ff [2];
   hpe_pkg::job_type new_job;
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff, count_in;
   logic       push, pop;

   always_comb begin
      new_job.code      = hpe_pkg::huff_code(req_data.symbol);
      new_job.len       = hpe_pkg::HUFF_LEN[req_data.symbol];
      new_job.first     = req_data.first;
      new_job.final_req = req_data.final_req;
      new_job.room      = req_data.room;
   end

   assign req_ready = (count_ff != 2'd2);
   assign push      = req_valid && req_ready;
   assign job_valid = (count_ff != 2'd0);
   assign pop       = job_valid && job_ready;
   assign job_data  = slot_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= new_job;
      end
   end

   a_count_max: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3) else $error("queue count out of range");
   a_full_no_push: assert property (@(posedge clock) disable iff (reset)
      (count_ff == 2'd2) |-> !push) else $error("push into full queue");
   a_count_track: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + 2'd1))
      else $error("queue count did not follow push");

endmodule

### design/hpe_back.sv
// ----------------------------------------------------------------------------
// hpe_back
// Appends each code to the bit accumulator, emits one output byte per cycle
// unless stalled, then the padded tail, tracking output room, string aborts.
// ----------------------------------------------------------------------------
module hpe_back #(
   parameter int ROOM_LIMIT = 65535
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              job_valid,
   output logic              job_ready,
   input  hpe_pkg::job_type  job_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output hpe_pkg::rsp_type  rsp_data
);

   localparam int ACC_W = hpe_pkg::CODE_W + 7;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EMIT = 2'b10
   } state_type;

   state_type         state_ff, state_in;
   logic [6:0]        pend_ff, pend_in;
   logic [2:0]        pcnt_ff, pcnt_in;
   logic [15:0]       room_ff, room_in;
   logic              abort_ff, abort_in;
   logic [ACC_W-1:0]  acc_ff, acc_in;
   logic [5:0]        cnt_ff, cnt_in;
   logic              last_ff, last_in;
   logic              out_valid_ff, out_valid_in;
   hpe_pkg::rsp_type  out_ff, out_in;

   logic              take;
   logic              out_free;
   logic [15:0]       room_load;
   logic [6:0]        base_bits;
   logic [2:0]        base_cnt;
   logic [ACC_W-1:0]  pad_word;
   logic [2:0]        pad;

   assign out_free  = !out_valid_ff || rsp_ready;
   assign job_ready = (state_ff == ST_IDLE);
   assign take      = job_valid && job_ready;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   always_comb begin
      if (ROOM_LIMIT < 65535 && {16'd0, job_data.room} > 32'(ROOM_LIMIT)) begin
         room_load = 16'(ROOM_LIMIT);
      end else begin
         room_load = job_data.room;
      end
      base_bits = job_data.first ? 7'd0 : pend_ff;
      base_cnt  = job_data.first ? 3'd0 : pcnt_ff;
      pad       = 3'd0 - cnt_ff[2:0];
      pad_word  = (acc_ff << pad) | ACC_W'((8'd1 << pad) - 8'd1);
   end

   always_comb begin
      state_in     = state_ff;
      pend_in      = pend_ff;
      pcnt_in      = pcnt_ff;
      room_in      = room_ff;
      abort_in     = abort_ff;
      acc_in       = acc_ff;
      cnt_in       = cnt_ff;
      last_in      = last_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      out_in       = out_ff;
      case (state_ff)
         ST_IDLE: begin
            if (take) begin
               if (job_data.first) begin
                  room_in  = room_load;
                  abort_in = 1'b0;
                  pend_in  = 7'd0;
                  pcnt_in  = 3'd0;
               end
               if (job_data.first || !abort_ff) begin
                  acc_in   = (ACC_W'(base_bits) << job_data.len) | ACC_W'(job_data.code);
                  cnt_in   = 6'(base_cnt) + 6'(job_data.len);
                  last_in  = job_data.final_req;
                  state_in = ST_EMIT;
               end
            end
         end
         ST_EMIT: begin
            if (cnt_ff >= 6'd8 || (last_ff && cnt_ff != 6'd0)) begin
               if (out_free) begin
                  out_valid_in = 1'b1;
                  if (room_ff == 16'd0) begin
                     out_in.out_byte = 8'd0;
                     out_in.out_end  = 1'b1;
                     out_in.overflow = 1'b1;
                     abort_in = 1'b1;
                     pend_in  = 7'd0;
                     pcnt_in  = 3'd0;
                     state_in = ST_IDLE;
                  end else begin
                     room_in = room_ff - 16'd1;
                     out_in.overflow = 1'b0;
                     if (cnt_ff >= 6'd8) begin
                        cnt_in = cnt_ff - 6'd8;
                        out_in.out_byte = 8'(acc_ff >> (cnt_ff - 6'd8));
                        out_in.out_end  = last_ff && (cnt_ff == 6'd8);
                     end else begin
                        cnt_in = 6'd0;
                        out_in.out_byte = pad_word[7:0];
                        out_in.out_end  = 1'b1;
                     end
                  end
               end
            end else begin
               state_in = ST_IDLE;
               if (last_ff) begin
                  pend_in = 7'd0;
                  pcnt_in = 3'd0;
               end else begin
                  pend_in = 7'(acc_ff & ((ACC_W'(1) << cnt_ff) - ACC_W'(1)));
                  pcnt_in = cnt_ff[2:0];
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pend_ff      <= 7'd0;
         pcnt_ff      <= 3'd0;
         room_ff      <= 16'd0;
         abort_ff     <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         pcnt_ff      <= pcnt_in;
         room_ff      <= room_in;
         abort_ff     <= abort_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff  <= acc_in;
      cnt_ff  <= cnt_in;
      last_ff <= last_in;
      out_ff  <= out_in;
   end

   a_state_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff)) else $error("state not one-hot");
   a_ovf_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.overflow) |-> rsp_data.out_end)
      else $error("overflow beat without end mark");
   a_ovf_abort: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && out_free && room_ff == 16'd0
       && (cnt_ff >= 6'd8 || (last_ff && cnt_ff != 6'd0))) |=> abort_ff)
      else $error("overflow did not abort string");

endmodule

### sim/hpack_huffman_string_encoder_tb.sv
// ----------------------------------------------------------------------------
// hpack_huffman_string_encoder_tb
// Self-checking bench for the HPACK static Huffman string encoder. Strings are
// sent byte by byte with random gaps, and the output side stalls at random.
// A scoreboard class tracks the pending bits and the room left for each string
// and queues the bytes that should come out, which are compared in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hpack_huffman_string_encoder_tb;

   localparam int LIMIT_CYCLES = 200000;

   class encoder_scoreboard;
      hpe_pkg::rsp_type byte_queue[$];
      logic [6:0]  held_bits;
      int unsigned held_count;
      logic [15:0] room_left;
      bit          aborted;
      int          errors;

      function new();
         held_bits = '0;
         held_count = 0;
         room_left = '0;
         aborted = 0;
         errors = 0;
      endfunction

      function void push_byte(logic [7:0] b, bit last_mark, bit ovf);
         hpe_pkg::rsp_type r;
         r.out_byte = b;
         r.out_end = last_mark;
         r.overflow = ovf;
         byte_queue.push_back(r);
         if (ovf) begin
            aborted = 1;
            held_bits = '0;
            held_count = 0;
         end
      endfunction

      function void note_input(hpe_pkg::req_type q);
         logic [63:0] acc;
         int unsigned cnt;
         int unsigned len;
         int unsigned pad;
         len = 32'(hpe_pkg::HUFF_LEN[q.symbol]);
         if (q.first) begin
            room_left = q.room;
            held_bits = '0;
            held_count = 0;
            aborted = 0;
         end else if (aborted) begin
            return;
         end
         cnt = held_count + len;
         acc = (64'(held_bits) << len) | 64'(hpe_pkg::huff_code(q.symbol));
         while (cnt >= 8) begin
            if (room_left == 0) begin
               push_byte(8'h00, 1'b1, 1'b1);
               return;
            end
            cnt -= 8;
            room_left--;
            push_byte(8'(acc >> cnt), q.final_req && cnt == 0, 1'b0);
         end
         if (q.final_req) begin
            if (cnt > 0) begin
               pad = 8 - cnt;
               if (room_left == 0) begin
                  push_byte(8'h00, 1'b1, 1'b1);
                  return;
               end
               room_left--;
               push_byte(8'((acc << pad) | ((64'd1 << pad) - 1)), 1'b1, 1'b0);
            end
            held_bits = '0;
            held_count = 0;
         end else begin
            held_bits = 7'(acc & ((64'd1 << cnt) - 1));
            held_count = cnt;
         end
      endfunction

      function void check_output(hpe_pkg::rsp_type got);
         hpe_pkg::rsp_type exp;
         if (byte_queue.size() == 0) begin
            $display("%0t: unexpected output beat %h", $time, got);
            errors++;
            return;
         end
         exp = byte_queue.pop_front();
         if (got.out_byte !== exp.out_byte)
            $display("%0t: out_byte expected %h actual %h", $time, exp.out_byte, got.out_byte);
         if (got.out_end !== exp.out_end)
            $display("%0t: out_end expected %b actual %b", $time, exp.out_end, got.out_end);
         if (got.overflow !== exp.overflow)
            $display("%0t: overflow expected %b actual %b", $time, exp.overflow, got.overflow);
         if (got !== exp)
            errors++;
      endfunction
   endclass

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   hpe_pkg::req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   hpe_pkg::rsp_type rsp_data;

   encoder_scoreboard board;
   int  cycle_count = 0;
   bit  tx_calm;
   bit  rx_calm;
   bit  hold_req;
   bit  hold_started = 0;
   int  hold_cycles = 0;

   hpack_huffman_string_encoder i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   initial begin
      reset = 1;
      repeat (2) @(posedge clock);
      reset <= 0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // Output side: random stalls, a calm stretch, and one long hold-off.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         board.check_output(rsp_data);
      if (reset) begin
         rsp_ready <= 0;
      end else if (hold_req && !hold_started) begin
         hold_started <= 1;
         hold_cycles <= 59;
         rsp_ready <= 0;
      end else if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_ready <= 0;
      end else begin
         rsp_ready <= rx_calm ? 1'b1 : ($urandom_range(99) >= 33);
      end
   end

   task automatic send_byte(logic [7:0] sym, bit first, bit last_mark, logic [15:0] room);
      hpe_pkg::req_type q;
      q.symbol = sym;
      q.first = first;
      q.final_req = last_mark;
      q.room = room;
      while (!tx_calm && $urandom_range(99) < 33) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      req_data <= q;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      board.note_input(q);
   endtask

   task automatic send_string(int n, logic [15:0] room);
      for (int i = 0; i < n; i++)
         send_byte(8'($urandom), i == 0, i == n - 1, room);
   endtask

   initial begin
      int wait_count;
      board = new();
      tx_calm = 0;
      rx_calm = 0;
      hold_req = 0;
      req_valid = 0;
      req_data = '0;
      @(posedge clock);
      while (reset) @(posedge clock);

      // Directed part.
      send_byte(8'd0, 0, 0, 16'h0000);
      send_byte(8'd48, 1, 1, 16'hffff);
      send_byte(8'd255, 1, 0, 16'hffff);
      send_byte(8'd10, 0, 1, 16'h0000);
      send_byte(8'd22, 1, 1, 16'h0001);
      send_byte(8'd48, 1, 1, 16'h0000);
      send_byte(8'd97, 1, 0, 16'h0001);
      send_byte(8'd97, 0, 0, 16'h0000);
      send_byte(8'd97, 0, 1, 16'h0000);
      send_byte(8'd1, 0, 0, 16'h5555);
      send_byte(8'd128, 1, 0, 16'h0002);
      send_byte(8'd255, 0, 0, 16'haaaa);
      send_byte(8'd13, 0, 1, 16'h0000);
      send_byte(8'd88, 1, 1, 16'h0001);
      send_byte(8'd57, 0, 1, 16'h0000);
      send_byte(8'd127, 0, 0, 16'h0000);

      // Long receiver hold-off while the sender keeps offering beats.
      hold_req = 1;
      tx_calm = 1;
      send_string(8, 16'h0100);
      tx_calm = 0;

      // Random strings, mostly well formed with ample room.
      for (int s = 0; s < 22; s++) begin
         rx_calm = (s >= 8 && s < 12);
         tx_calm = rx_calm;
         case ($urandom_range(9))
            0: send_byte(8'($urandom), 1'($urandom_range(1)), 1'($urandom_range(1)),
                         16'($urandom));
            1, 2: send_string($urandom_range(1, 6), 16'($urandom_range(5)));
            default: send_string($urandom_range(1, 6), 16'($urandom));
         endcase
      end
      req_valid <= 0;
      rx_calm = 0;
      tx_calm = 0;

      wait_count = 0;
      while (board.byte_queue.size() != 0 && wait_count < 10000) begin
         @(posedge clock);
         wait_count++;
      end
      repeat (40) @(posedge clock);
      if (board.errors == 0 && board.byte_queue.size() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

### files.f
design/hpe_pkg.sv
design/hpe_front.sv
design/hpe_back.sv
design/hpack_huffman_string_encoder.sv
sim/hpack_huffman_string_encoder_tb.sv
